/* hw/rtl/dfsp_pkg.sv */
// Shared types and constants for the deauthentication frame SSID parser.
// No dependencies; the parser, report and top-level files import this package.
package dfsp_pkg;

  localparam int unsigned MAC_W          = 48;
  localparam int unsigned MAC_BYTES      = 6;
  localparam int unsigned MAC_FIRST_BYTE = 10;
  localparam int unsigned SSID_LEN_W     = 6;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned CFG_DATA_W     = 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ELEM_OFFSET  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MATCH_SUBTYP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SSID_ID      = 2'd2;

  // Configuration reset values
  localparam logic [7:0] ELEM_OFFSET_RST  = 8'd36;
  localparam logic [3:0] MATCH_SUBTYP_RST = 4'hC;
  localparam logic [7:0] SSID_ID_RST      = 8'h00;

  // Result item kinds
  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_CHAR   = 1'b1;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
    logic       is_management;
  } in_item_t;

  typedef struct packed {
    logic                  item_kind;
    logic [MAC_W-1:0]      source_mac;
    logic                  ssid_found;
    logic [SSID_LEN_W-1:0] ssid_length;
    logic [7:0]            ssid_char;
    logic                  last_of_report;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic [7:0] elem_offset;
    logic [3:0] match_subtype;
    logic [7:0] ssid_id;
  } cfg_t;

  // Frame-end hand-off from the parser to the report stage
  typedef struct packed {
    logic                  start;
    logic [MAC_W-1:0]      mac;
    logic                  found;
    logic [SSID_LEN_W-1:0] len;
  } rpt_start_t;

endpackage

/* hw/rtl/dfsp_stream_if.sv */
// Valid/ready channel carrying one payload per transaction.
// Payload type comes in as a parameter; typically a dfsp_pkg struct.
interface dfsp_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* hw/rtl/dfsp_parser.sv */
// Input register and per-byte frame parser: subtype, MAC, tagged-element walk,
// SSID capture. Depends on dfsp_pkg and dfsp_stream_if.
module dfsp_parser import dfsp_pkg::*; #(
  parameter int unsigned MAX_FRAME_BYTES = 4096,
  parameter int unsigned SSID_MAX_BYTES  = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  dfsp_stream_if.sink                 in_ch,
  input  cfg_t                        cfg,
  input  logic                        rpt_free,
  output rpt_start_t                  rpt_start,
  output logic [SSID_MAX_BYTES*8-1:0] ssid_bytes
);

  localparam int unsigned POS_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam int unsigned CNT_W = $clog2(SSID_MAX_BYTES + 1);
  localparam int unsigned IDX_W = (SSID_MAX_BYTES > 1) ? $clog2(SSID_MAX_BYTES) : 1;

  typedef enum logic [1:0] {PH_ID, PH_LEN, PH_BODY, PH_DONE} phase_t;
  typedef enum logic [1:0] {SS_NONE, SS_CAPT, SS_FOUND} ssid_st_t;

  logic       in_vld_r;
  in_item_t   in_r;
  logic       advance;
  logic       take;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [3:0]       subtype_r, subtype_nxt;
  logic             mgmt_r, mgmt_nxt;
  logic [MAC_W-1:0] mac_r, mac_nxt;
  logic [POS_W-1:0] next_pos_r, next_pos_nxt;
  phase_t           phase_r, phase_nxt;
  logic [7:0]       id_r, id_nxt;
  logic [7:0]       body_r, body_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  ssid_st_t         ssid_r, ssid_nxt;
  logic [7:0]       store_r [SSID_MAX_BYTES];
  logic             wr_en;
  logic [IDX_W-1:0] wr_idx;
  logic [7:0]       b;

  // An end byte waits in the input register until the report stage is free
  assign advance     = !(in_r.frame_end && !rpt_free);
  assign in_ch.ready = !in_vld_r || advance;
  assign take        = in_vld_r && advance;
  assign b           = in_r.frame_byte;
  assign wr_idx      = cnt_r[IDX_W-1:0];

  always_comb begin
    pos_nxt      = pos_r;
    subtype_nxt  = subtype_r;
    mgmt_nxt     = mgmt_r;
    mac_nxt      = mac_r;
    next_pos_nxt = next_pos_r;
    phase_nxt    = phase_r;
    id_nxt       = id_r;
    body_nxt     = body_r;
    cnt_nxt      = cnt_r;
    ssid_nxt     = ssid_r;
    wr_en        = 1'b0;
    rpt_start    = '0;
    if (take) begin
      if (pos_r != POS_W'(MAX_FRAME_BYTES)) begin
        if (pos_r == '0) begin
          subtype_nxt = b[7:4];
          mgmt_nxt    = in_r.is_management;
        end
        for (int j = 0; j < MAC_BYTES; j++) begin
          if (pos_r == POS_W'(MAC_FIRST_BYTE + j)) begin
            mac_nxt[MAC_W-1-8*j -: 8] = b;
          end
        end
        unique case (phase_r)
          PH_ID: begin
            if (pos_r >= next_pos_r) begin
              id_nxt    = b;
              phase_nxt = PH_LEN;
            end
          end
          PH_LEN: begin
            body_nxt = b;
            if (id_r == cfg.ssid_id && b <= 8'(SSID_MAX_BYTES)) begin
              cnt_nxt = '0;
              if (b == 8'd0) begin
                ssid_nxt  = SS_FOUND;
                phase_nxt = PH_DONE;
              end else begin
                ssid_nxt  = SS_CAPT;
                phase_nxt = PH_BODY;
              end
            end else if (b == 8'd0) begin
              phase_nxt    = PH_ID;
              next_pos_nxt = pos_r + 1'b1;
            end else begin
              phase_nxt = PH_BODY;
            end
          end
          PH_BODY: begin
            if (ssid_r == SS_CAPT && cnt_r < CNT_W'(SSID_MAX_BYTES)) begin
              wr_en   = 1'b1;
              cnt_nxt = cnt_r + 1'b1;
            end
            body_nxt = body_r - 8'd1;
            if (body_nxt == 8'd0) begin
              if (ssid_r == SS_CAPT) begin
                ssid_nxt  = SS_FOUND;
                phase_nxt = PH_DONE;
              end else begin
                phase_nxt    = PH_ID;
                next_pos_nxt = pos_r + 1'b1;
              end
            end
          end
          PH_DONE: begin
          end
        endcase
        pos_nxt = pos_r + 1'b1;
      end
      if (in_r.frame_end) begin
        // Report from the updated state, then restart for the next frame
        rpt_start.start = mgmt_nxt && (subtype_nxt == cfg.match_subtype);
        rpt_start.mac   = mac_nxt;
        rpt_start.found = (ssid_nxt == SS_FOUND);
        rpt_start.len   = (ssid_nxt == SS_FOUND) ? SSID_LEN_W'(cnt_nxt) : '0;
        pos_nxt      = '0;
        subtype_nxt  = '0;
        mgmt_nxt     = 1'b0;
        mac_nxt      = '0;
        next_pos_nxt = POS_W'(cfg.elem_offset);
        phase_nxt    = PH_ID;
        id_nxt       = '0;
        body_nxt     = '0;
        cnt_nxt      = '0;
        ssid_nxt     = SS_NONE;
      end
    end
  end

  // Hand the store over including a byte written on this same cycle
  always_comb begin
    for (int i = 0; i < SSID_MAX_BYTES; i++) begin
      ssid_bytes[i*8 +: 8] = (wr_en && wr_idx == IDX_W'(i)) ? b : store_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r   <= 1'b0;
      pos_r      <= '0;
      subtype_r  <= '0;
      mgmt_r     <= 1'b0;
      mac_r      <= '0;
      next_pos_r <= POS_W'(ELEM_OFFSET_RST);
      phase_r    <= PH_ID;
      id_r       <= '0;
      body_r     <= '0;
      cnt_r      <= '0;
      ssid_r     <= SS_NONE;
    end else begin
      if (in_ch.ready) begin
        in_vld_r <= in_ch.valid;
      end
      pos_r      <= pos_nxt;
      subtype_r  <= subtype_nxt;
      mgmt_r     <= mgmt_nxt;
      mac_r      <= mac_nxt;
      next_pos_r <= next_pos_nxt;
      phase_r    <= phase_nxt;
      id_r       <= id_nxt;
      body_r     <= body_nxt;
      cnt_r      <= cnt_nxt;
      ssid_r     <= ssid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_r <= in_ch.payload;
    end
    if (wr_en) begin
      store_r[wr_idx] <= b;
    end
  end

endmodule

/* hw/rtl/dfsp_report.sv */
// Report buffer and output register: emits the header and SSID bytes of one
// frame while the parser moves on. Depends on dfsp_pkg and dfsp_stream_if.
module dfsp_report import dfsp_pkg::*; #(
  parameter int unsigned SSID_MAX_BYTES = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  rpt_start_t                  rpt_start,
  input  logic [SSID_MAX_BYTES*8-1:0] ssid_bytes,
  output logic                        rpt_free,
  dfsp_stream_if.source               out_ch
);

  localparam int unsigned CNT_W = $clog2(SSID_MAX_BYTES + 1);
  localparam int unsigned IDX_W = (SSID_MAX_BYTES > 1) ? $clog2(SSID_MAX_BYTES) : 1;

  logic             busy_r;
  logic [CNT_W-1:0] idx_r;
  logic [CNT_W-1:0] len_r;
  logic             found_r;
  logic [MAC_W-1:0] mac_r;
  logic [7:0]       store_r [SSID_MAX_BYTES];
  logic             out_vld_r;
  out_item_t        out_r;

  logic             item_last;
  logic             load;
  logic [CNT_W-1:0] idx_m1;
  out_item_t        item;

  assign item_last = (idx_r == len_r);
  assign load      = busy_r && (!out_vld_r || out_ch.ready);
  assign rpt_free  = !busy_r || (load && item_last);
  assign idx_m1    = idx_r - 1'b1;

  always_comb begin
    item.item_kind      = (idx_r == '0) ? KIND_HEADER : KIND_CHAR;
    item.source_mac     = mac_r;
    item.ssid_found     = found_r;
    item.ssid_length    = SSID_LEN_W'(len_r);
    item.ssid_char      = (idx_r == '0) ? 8'd0 : store_r[idx_m1[IDX_W-1:0]];
    item.last_of_report = item_last;
  end

  assign out_ch.valid   = out_vld_r;
  assign out_ch.payload = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      idx_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (rpt_start.start) begin
        busy_r <= 1'b1;
        idx_r  <= '0;
      end else if (load) begin
        if (item_last) begin
          busy_r <= 1'b0;
        end
        idx_r <= idx_r + 1'b1;
      end
      if (load) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rpt_start.start) begin
      len_r   <= CNT_W'(rpt_start.len);
      found_r <= rpt_start.found;
      mac_r   <= rpt_start.mac;
      for (int i = 0; i < SSID_MAX_BYTES; i++) begin
        store_r[i] <= ssid_bytes[i*8 +: 8];
      end
    end
    if (load) begin
      out_r <= item;
    end
  end

  a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    rpt_start.start |-> rpt_free)
    else $error("report started while previous report still pending");

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> idx_r <= len_r)
    else $error("report index ran past length");

  a_header_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_r.item_kind == KIND_HEADER) |->
      (out_r.last_of_report == (out_r.ssid_length == '0)) &&
      (out_r.ssid_found || out_r.ssid_length == '0))
    else $error("inconsistent header item");

endmodule

/* hw/rtl/deauth_frame_ssid_parser.sv */
// Top level of the deauthentication frame SSID parser: configuration registers,
// parser and report stages. Depends on dfsp_pkg, dfsp_stream_if, dfsp_parser, dfsp_report.

// The block takes an 802.11 frame one byte per in_ch transaction, with a
// management flag (sampled on byte 0) and an end marker on the last byte.
// It takes one byte per cycle unless an end byte is held back: each byte passes
// through an input register and then the parsing logic. At frame end, a
// management frame whose subtype matches produces a report on out_ch: one
// header (source MAC, SSID found flag, length) followed by one transaction per
// SSID byte, at one per cycle while out_ch is ready. The report sits in its own
// buffer, so the next frame streams in while it drains; only the end byte of a
// following frame waits, in the input register, until the previous report has
// been handed to the output register. Configuration writes on cfg_ch are always
// taken. The element start offset is latched at each frame end, so a new offset
// applies to the frame that starts after the next frame end.
module deauth_frame_ssid_parser import dfsp_pkg::*; #(
  parameter int unsigned MAX_FRAME_BYTES = 4096,
  parameter int unsigned SSID_MAX_BYTES  = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  dfsp_stream_if.sink   in_ch,
  dfsp_stream_if.sink   cfg_ch,
  dfsp_stream_if.source out_ch
);

  cfg_t                        cfg_r;
  rpt_start_t                  rpt_start;
  logic                        rpt_free;
  logic [SSID_MAX_BYTES*8-1:0] ssid_bytes;

  // Configuration registers; unknown indexes drop the write
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.elem_offset   <= ELEM_OFFSET_RST;
      cfg_r.match_subtype <= MATCH_SUBTYP_RST;
      cfg_r.ssid_id       <= SSID_ID_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.payload.index)
        REG_ELEM_OFFSET:  cfg_r.elem_offset   <= cfg_ch.payload.data;
        REG_MATCH_SUBTYP: cfg_r.match_subtype <= cfg_ch.payload.data[3:0];
        REG_SSID_ID:      cfg_r.ssid_id       <= cfg_ch.payload.data;
        default: begin
        end
      endcase
    end
  end

  // Parse bytes and capture the SSID of the current frame
  dfsp_parser #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
    .SSID_MAX_BYTES  (SSID_MAX_BYTES)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg        (cfg_r),
    .rpt_free   (rpt_free),
    .rpt_start  (rpt_start),
    .ssid_bytes (ssid_bytes)
  );

  // Hold the finished report and stream it out
  dfsp_report #(
    .SSID_MAX_BYTES (SSID_MAX_BYTES)
  ) u_report (
    .clk        (clk),
    .rst_n      (rst_n),
    .rpt_start  (rpt_start),
    .ssid_bytes (ssid_bytes),
    .rpt_free   (rpt_free),
    .out_ch     (out_ch)
  );

endmodule
